/* hw/rtl/wsct_pkg.sv */
// shared types and constants of the window sign coherence tracker
package wsct_pkg;

    // register field widths and reset values
    localparam int FILL_W  = 9;
    localparam int LEVEL_W = 17;
    localparam int QUO_W   = 17;
    localparam int DIV_STEPS = 17;
    localparam int STEP_W  = 5;

    localparam logic [FILL_W-1:0]  RST_WINDOW_LENGTH = 9'd64;
    localparam logic [FILL_W-1:0]  RST_MIN_FILL      = 9'd1;
    localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL    = 17'd52429;
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL     = 17'd32768;

    // register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FILL      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL     = 2'd3;

    typedef struct packed {
        logic [FILL_W-1:0]  window_length;
        logic [FILL_W-1:0]  min_fill;
        logic [LEVEL_W-1:0] high_level;
        logic [LEVEL_W-1:0] low_level;
    } t_cfg;

    // one classified request handed from the window side to the divider side
    typedef struct packed {
        logic              eval;
        logic [FILL_W-1:0] fill;
        logic [FILL_W-1:0] agree;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        FR_IDLE,
        FR_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

/* hw/rtl/wsct_regs.sv */
// configuration registers behind the apb-style port
module wsct_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output wsct_pkg::t_cfg      o_cfg,
    output logic                o_clear
);

    wsct_pkg::t_cfg                    r_cfg;
    logic                              w_write;
    logic [wsct_pkg::REG_IDX_W-1:0]    w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite;
    assign w_index = paddr[3:2];
    assign o_clear = w_write;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= wsct_pkg::RST_WINDOW_LENGTH;
            r_cfg.min_fill      <= wsct_pkg::RST_MIN_FILL;
            r_cfg.high_level    <= wsct_pkg::RST_HIGH_LEVEL;
            r_cfg.low_level     <= wsct_pkg::RST_LOW_LEVEL;
        end else if (w_write) begin
            unique case (w_index)
                wsct_pkg::REG_WINDOW_LENGTH: begin
                    r_cfg.window_length <= pwdata[wsct_pkg::FILL_W-1:0];
                end
                wsct_pkg::REG_MIN_FILL: begin
                    r_cfg.min_fill <= pwdata[wsct_pkg::FILL_W-1:0];
                end
                wsct_pkg::REG_HIGH_LEVEL: begin
                    r_cfg.high_level <= pwdata[wsct_pkg::LEVEL_W-1:0];
                end
                wsct_pkg::REG_LOW_LEVEL: begin
                    r_cfg.low_level <= pwdata[wsct_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read data
    always_comb begin
        prdata = '0;
        unique case (w_index)
            wsct_pkg::REG_WINDOW_LENGTH: prdata = 32'(r_cfg.window_length);
            wsct_pkg::REG_MIN_FILL:      prdata = 32'(r_cfg.min_fill);
            wsct_pkg::REG_HIGH_LEVEL:    prdata = 32'(r_cfg.high_level);
            wsct_pkg::REG_LOW_LEVEL:     prdata = 32'(r_cfg.low_level);
            default:                     prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/wsct_front.sv */
// window side: accepts samples, keeps the ring window, sum and negative count
module wsct_front #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsct_pkg::t_cfg                i_cfg,
    input  logic                          i_clear,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_push,
    output wsct_pkg::t_job                o_job,
    input  wsct_pkg::t_queue_status       i_q_status
);

    localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + wsct_pkg::FILL_W;
    localparam int FW    = wsct_pkg::FILL_W;

    wsct_pkg::t_front_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_store [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PW-1:0]          r_wptr;
    logic [FW-1:0]          r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [FW-1:0]          r_neg;

    logic [FW-1:0]    w_len;
    logic             w_full;
    logic [SUM_W-1:0] w_old_ext;
    logic [SUM_W-1:0] w_new_ext;
    logic [SUM_W-1:0] w_sum_next;
    logic [FW-1:0]    w_neg_next;
    logic [FW-1:0]    w_fill_next;
    logic [PW-1:0]    w_wptr_next;
    logic             w_accept;

    // effective window length
    always_comb begin
        if (i_cfg.window_length == '0) begin
            w_len = FW'(1);
        end else if (32'(i_cfg.window_length) > 32'(MAX_WINDOW)) begin
            w_len = FW'(MAX_WINDOW);
        end else begin
            w_len = i_cfg.window_length;
        end
    end

    // window update arithmetic
    assign w_full      = (r_fill >= w_len);
    assign w_old_ext   = {{FW{r_old[SAMPLE_BITS-1]}}, r_old};
    assign w_new_ext   = {{FW{r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign w_sum_next  = r_sum - (w_full ? w_old_ext : '0) + w_new_ext;
    assign w_neg_next  = r_neg - FW'(w_full & r_old[SAMPLE_BITS-1])
                         + FW'(r_sample[SAMPLE_BITS-1]);
    assign w_fill_next = w_full ? r_fill : r_fill + FW'(1);

    always_comb begin
        if ((32'(r_wptr) + 32'd1) == 32'(w_len)) begin
            w_wptr_next = '0;
        end else begin
            w_wptr_next = r_wptr + PW'(1);
        end
    end

    // classified request for the divider side
    always_comb begin
        o_job.fill  = w_fill_next;
        o_job.eval  = (w_fill_next >= i_cfg.min_fill) && (w_fill_next != '0);
        o_job.agree = w_sum_next[SUM_W-1] ? w_neg_next : (w_fill_next - w_neg_next);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsct_pkg::FR_IDLE: begin
                if (i_valid) begin
                    n_state = wsct_pkg::FR_UPDATE;
                end
            end
            wsct_pkg::FR_UPDATE: begin
                if (!i_q_status.full) begin
                    n_state = wsct_pkg::FR_IDLE;
                end
            end
            default: n_state = wsct_pkg::FR_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            wsct_pkg::FR_IDLE:   o_ready = 1'b1;
            wsct_pkg::FR_UPDATE: o_push  = ~i_q_status.full;
            default: begin
            end
        endcase
    end

    assign w_accept = i_valid & o_ready;

    // sample store, read ahead at the write pointer
    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_store[r_wptr] <= r_sample;
        end
        r_old <= r_store[r_wptr];
    end

    // accepted sample
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsct_pkg::FR_IDLE;
            r_wptr  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_neg   <= '0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_wptr <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_neg  <= '0;
            end else if (o_push) begin
                r_wptr <= w_wptr_next;
                r_fill <= w_fill_next;
                r_sum  <= w_sum_next;
                r_neg  <= w_neg_next;
            end
        end
    end

endmodule

/* hw/rtl/wsct_queue.sv */
// two-entry request queue between the window side and the divider side
module wsct_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  wsct_pkg::t_job           i_job,
    input  logic                     i_pop,
    output wsct_pkg::t_job           o_job,
    output wsct_pkg::t_queue_status  o_status
);

    wsct_pkg::t_job r_entry [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_job           = r_entry[r_rd];
    assign o_status.full   = (r_cnt == 2'd2);
    assign o_status.empty  = (r_cnt == 2'd0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_job;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/wsct_back.sv */
// divider side: serial coherence division, level tests, events and counters
module wsct_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wsct_pkg::t_cfg                       i_cfg,
    input  wsct_pkg::t_job                       i_job,
    input  wsct_pkg::t_queue_status              i_q_status,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [wsct_pkg::QUO_W-1:0]           o_coherence,
    output logic                                 o_high_event,
    output logic                                 o_low_event,
    output logic [31:0]                          o_high_event_count,
    output logic [31:0]                          o_low_event_count,
    output logic [31:0]                          o_sample_count
);

    localparam int FW = wsct_pkg::FILL_W;

    wsct_pkg::t_back_state r_state, n_state;

    logic                          r_eval;
    logic [FW-1:0]                 r_fill;
    logic [FW-1:0]                 r_agree;
    logic [FW-1:0]                 r_rem;
    logic [wsct_pkg::QUO_W-1:0]    r_quo;
    logic [wsct_pkg::STEP_W-1:0]   r_step;
    logic                          r_prev_high;
    logic                          r_prev_low;
    logic [31:0]                   r_high_cnt;
    logic [31:0]                   r_low_cnt;
    logic [31:0]                   r_total_cnt;
    logic                          r_valid;

    logic          w_step;
    logic          w_load;
    logic          w_last;
    logic [FW:0]   w_trial;
    logic          w_ge;
    logic          w_cur_high;
    logic          w_cur_low;
    logic          w_high_ev;
    logic          w_low_ev;

    assign w_last = (r_step == wsct_pkg::STEP_W'(wsct_pkg::DIV_STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wsct_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = i_job.eval ? wsct_pkg::BK_DIV : wsct_pkg::BK_DONE;
                end
            end
            wsct_pkg::BK_DIV: begin
                if (w_last) begin
                    n_state = wsct_pkg::BK_DONE;
                end
            end
            wsct_pkg::BK_DONE: begin
                if (!r_valid || i_ready) begin
                    n_state = wsct_pkg::BK_IDLE;
                end
            end
            default: n_state = wsct_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = 1'b0;
        w_step = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            wsct_pkg::BK_IDLE: o_pop  = ~i_q_status.empty;
            wsct_pkg::BK_DIV:  w_step = 1'b1;
            wsct_pkg::BK_DONE: w_load = ~r_valid | i_ready;
            default: begin
            end
        endcase
    end

    // restoring division step: agree * 65536 / fill, one quotient bit a cycle
    assign w_trial = (r_step == '0) ? {1'b0, r_agree} : {r_rem, 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_fill});

    // level tests on the quotient and remainder
    assign w_cur_high = (r_quo >= i_cfg.high_level);
    assign w_cur_low  = (r_quo < i_cfg.low_level)
                        || ((r_quo == i_cfg.low_level) && (r_rem == '0));
    assign w_high_ev  = r_eval & w_cur_high & ~r_prev_high;
    assign w_low_ev   = r_eval & w_cur_low & ~r_prev_low;

    // division datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_eval  <= i_job.eval;
            r_fill  <= i_job.fill;
            r_agree <= i_job.agree;
            r_rem   <= '0;
            r_quo   <= '0;
        end else if (w_step) begin
            r_rem <= w_ge ? FW'(w_trial - {1'b0, r_fill}) : FW'(w_trial);
            r_quo <= {r_quo[wsct_pkg::QUO_W-2:0], w_ge};
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_coherence  <= r_eval ? r_quo : '0;
            o_high_event <= w_high_ev;
            o_low_event  <= w_low_ev;
        end
    end

    // control, edge history and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsct_pkg::BK_IDLE;
            r_step      <= '0;
            r_prev_high <= 1'b0;
            r_prev_low  <= 1'b0;
            r_high_cnt  <= '0;
            r_low_cnt   <= '0;
            r_total_cnt <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (w_step) begin
                r_step <= r_step + wsct_pkg::STEP_W'(1);
            end
            if (w_load) begin
                r_valid     <= 1'b1;
                r_total_cnt <= r_total_cnt + 32'd1;
                if (r_eval) begin
                    r_prev_high <= w_cur_high;
                    r_prev_low  <= w_cur_low;
                end
                if (w_high_ev) begin
                    r_high_cnt <= r_high_cnt + 32'd1;
                end
                if (w_low_ev) begin
                    r_low_cnt <= r_low_cnt + 32'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_high_event_count = r_high_cnt;
    assign o_low_event_count  = r_low_cnt;
    assign o_sample_count     = r_total_cnt;

endmodule

/* hw/rtl/window_sign_coherence_tracker.sv */
// top level of the window sign coherence tracker
//
// Input channel (i_valid / o_ready / i_sample) takes one signed sample per
// request; output channel (o_valid / i_ready and the o_* fields) gives one
// result per sample, in order: the Q1.16 coherence of the window, the high
// and low event flags, and the wrapping event and sample counters.
// The window side accepts a sample, then updates the window (waiting while the
// queue is full) and hands a classified request to a two-entry queue, so it can
// take new samples while the divider is busy. The divider side pops a request,
// runs a restoring division of 17 steps (one quotient bit a cycle) and loads
// the output register; a steady stream is paced by the serial divider (pop,
// 17 division steps, load). Underfilled windows skip the division and go from
// pop straight to load.
// When the receiver stalls, the result stays in the output register, the
// divider finishes its next request and waits, the queue fills and then
// o_ready drops. Reset (synchronous, active low) empties the window, clears
// counters and event history and loads the default register values; a
// register write over the apb-style port also empties the window and must
// only be issued while no request is in flight.
module window_sign_coherence_tracker #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wsct_pkg::QUO_W-1:0]       o_coherence,
    output logic                             o_high_event,
    output logic                             o_low_event,
    output logic [31:0]                      o_high_event_count,
    output logic [31:0]                      o_low_event_count,
    output logic [31:0]                      o_sample_count
);

    wsct_pkg::t_cfg          w_cfg;
    logic                    w_clear;
    logic                    w_push;
    logic                    w_pop;
    wsct_pkg::t_job          w_front_job;
    wsct_pkg::t_job          w_queue_job;
    wsct_pkg::t_queue_status w_q_status;

    // configuration registers
    wsct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_clear (w_clear)
    );

    // window side
    wsct_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_clear    (w_clear),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_push     (w_push),
        .o_job      (w_front_job),
        .i_q_status (w_q_status)
    );

    // request queue
    wsct_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_queue_job),
        .o_status (w_q_status)
    );

    // divider side and output register
    wsct_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_job              (w_queue_job),
        .i_q_status         (w_q_status),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_coherence        (o_coherence),
        .o_high_event       (o_high_event),
        .o_low_event        (o_low_event),
        .o_high_event_count (o_high_event_count),
        .o_low_event_count  (o_low_event_count),
        .o_sample_count     (o_sample_count)
    );

endmodule

/* tb/tb_window_sign_coherence_tracker.sv */
// self-checking testbench for the window sign coherence tracker
module tb_window_sign_coherence_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    // one result request as seen on the output channel
    typedef struct {
        logic [wsct_pkg::QUO_W-1:0] coherence;
        logic                       high_event;
        logic                       low_event;
        logic [31:0]                high_total;
        logic [31:0]                low_total;
        logic [31:0]                sample_total;
    } t_coherence_result;

    // window tracker mirror and the store of coherence results still owed
    class t_coherence_scoreboard;
        logic [wsct_pkg::FILL_W-1:0]  window_length;
        logic [wsct_pkg::FILL_W-1:0]  min_fill;
        logic [wsct_pkg::LEVEL_W-1:0] high_level;
        logic [wsct_pkg::LEVEL_W-1:0] low_level;
        logic signed [15:0]           ring[256];
        int unsigned                  wr_slot;
        int unsigned                  fill;
        int unsigned                  neg_count;
        int                           window_sum;
        bit                           was_high;
        bit                           was_low;
        logic [31:0]                  high_total;
        logic [31:0]                  low_total;
        logic [31:0]                  sample_total;
        t_coherence_result            owed_results[$];
        int unsigned                  mismatches;

        function new();
            window_length = wsct_pkg::RST_WINDOW_LENGTH;
            min_fill      = wsct_pkg::RST_MIN_FILL;
            high_level    = wsct_pkg::RST_HIGH_LEVEL;
            low_level     = wsct_pkg::RST_LOW_LEVEL;
            was_high      = 1'b0;
            was_low       = 1'b0;
            high_total    = '0;
            low_total     = '0;
            sample_total  = '0;
            mismatches    = 0;
            empty_window();
        endfunction

        function void empty_window();
            foreach (ring[k]) ring[k] = '0;
            wr_slot    = 0;
            fill       = 0;
            window_sum = 0;
            neg_count  = 0;
        endfunction

        // register write also empties the window, event history is kept
        function void write_register(logic [wsct_pkg::REG_IDX_W-1:0] idx,
                                     logic [31:0] value);
            case (idx)
                wsct_pkg::REG_WINDOW_LENGTH: window_length = value[wsct_pkg::FILL_W-1:0];
                wsct_pkg::REG_MIN_FILL:      min_fill      = value[wsct_pkg::FILL_W-1:0];
                wsct_pkg::REG_HIGH_LEVEL:    high_level    = value[wsct_pkg::LEVEL_W-1:0];
                wsct_pkg::REG_LOW_LEVEL:     low_level     = value[wsct_pkg::LEVEL_W-1:0];
                default: ;
            endcase
            empty_window();
        endfunction

        // accepted sample: update the window and work out its result
        function void record_sample(logic signed [15:0] smp);
            int unsigned       len;
            int unsigned       slot;
            int                oldest;
            longint unsigned   agree;
            longint unsigned   scaled;
            bit                now_high;
            bit                now_low;
            t_coherence_result res;

            len = (window_length == 0) ? 1 : ((window_length > 256) ? 256 : window_length);
            slot = wr_slot % len;
            res.coherence  = '0;
            res.high_event = 1'b0;
            res.low_event  = 1'b0;

            // drop the oldest sample once the window is full
            if (fill >= len) begin
                oldest = ring[slot];
                window_sum -= oldest;
                if (oldest < 0) neg_count--;
            end
            ring[slot] = smp;
            window_sum += smp;
            if (smp < 0) neg_count++;
            wr_slot = (slot + 1) % len;
            if (fill < len) fill++;

            // majority sign, coherence and threshold edges
            if (fill >= min_fill && fill > 0) begin
                agree  = (window_sum >= 0) ? (fill - neg_count) : neg_count;
                scaled = agree << 16;
                res.coherence = wsct_pkg::QUO_W'(scaled / fill);
                now_high = scaled >= longint'(high_level) * fill;
                now_low  = scaled <= longint'(low_level) * fill;
                if (now_high && !was_high) begin
                    res.high_event = 1'b1;
                    high_total++;
                end
                if (now_low && !was_low) begin
                    res.low_event = 1'b1;
                    low_total++;
                end
                was_high = now_high;
                was_low  = now_low;
            end
            sample_total++;

            res.high_total   = high_total;
            res.low_total    = low_total;
            res.sample_total = sample_total;
            owed_results.push_back(res);
        endfunction

        function void check_result(t_coherence_result got);
            t_coherence_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: coherence %0d counts %0d/%0d/%0d",
                             got.coherence, got.high_total, got.low_total,
                             got.sample_total);
                return;
            end
            want = owed_results.pop_front();
            if (got.coherence !== want.coherence || got.high_event !== want.high_event ||
                got.low_event !== want.low_event || got.high_total !== want.high_total ||
                got.low_total !== want.low_total ||
                got.sample_total !== want.sample_total) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at sample %0d:", want.sample_total);
                    $display("  expected coh %0d hev %0d lev %0d hcnt %0d lcnt %0d scnt %0d",
                             want.coherence, want.high_event, want.low_event,
                             want.high_total, want.low_total, want.sample_total);
                    $display("  actual   coh %0d hev %0d lev %0d hcnt %0d lcnt %0d scnt %0d",
                             got.coherence, got.high_event, got.low_event,
                             got.high_total, got.low_total, got.sample_total);
                end
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    localparam int TARGET_ITEMS = 1400;
    localparam int STALL_AT     = 150;
    localparam int STALL_CYCLES = 300;
    localparam int SETTLE       = 40;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [3:0]                 paddr     = '0;
    logic [31:0]                pwdata    = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_valid   = 1'b0;
    logic                       o_ready;
    logic signed [15:0]         i_sample  = '0;
    logic                       o_valid;
    logic                       i_ready   = 1'b0;
    logic [wsct_pkg::QUO_W-1:0] o_coherence;
    logic                       o_high_event;
    logic                       o_low_event;
    logic [31:0]                o_high_event_count;
    logic [31:0]                o_low_event_count;
    logic [31:0]                o_sample_count;

    t_coherence_scoreboard sb = new();
    int  samples_sent   = 0;
    int  results_taken  = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;

    // edge values: extremes, zero sum, negative sum against a positive majority
    logic signed [15:0] corner_samples[$] = '{
        16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh8001, 16'sh7ffe,
        16'sh5555, 16'shaaaa, 16'sd5, -16'sd5, 16'sd0, 16'sd1, 16'sd1, 16'sh8000,
        -16'sd2, -16'sd3, -16'sd100, 16'sd100, 16'sh7fff
    };

    window_sign_coherence_tracker DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample           (i_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_coherence        (o_coherence),
        .o_high_event       (o_high_event),
        .o_low_event        (o_low_event),
        .o_high_event_count (o_high_event_count),
        .o_low_event_count  (o_low_event_count),
        .o_sample_count     (o_sample_count)
    );

    always #10 i_clk = ~i_clk;

    // offer one sample request, keep valid high across back-to-back requests
    task automatic send_sample(input logic signed [15:0] smp);
        int gap;
        gap = sender_idles ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        do @(posedge i_clk); while (!o_ready);
        sb.record_sample(smp);
        samples_sent++;
    endtask

    // wait until every owed result is in, then let the block settle
    task automatic drain_window();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // setup and access phase, then idle before the next write
    task automatic apb_write(input logic [wsct_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int wlen, input int mfill, input int hlev,
                                 input int llev);
        drain_window();
        apb_write(wsct_pkg::REG_WINDOW_LENGTH, wlen);
        apb_write(wsct_pkg::REG_MIN_FILL, mfill);
        apb_write(wsct_pkg::REG_HIGH_LEVEL, hlev);
        apb_write(wsct_pkg::REG_LOW_LEVEL, llev);
        sender_idles   = $urandom_range(0, 3) != 0;
        receiver_idles = $urandom_range(0, 3) != 0;
    endtask

    // mostly biased signs so coherence sweeps across the levels, some noise
    function automatic logic signed [15:0] draw_sample(input int neg_pct);
        int                 pick;
        int                 mag;
        logic signed [15:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            v = 16'($urandom);
        end else if (pick < 14) begin
            v = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        end else if (pick < 18) begin
            v = '0;
        end else begin
            mag = $urandom_range(1, (pick < 60) ? 255 : 32767);
            v = ($urandom_range(0, 99) < neg_pct) ? 16'(-mag) : 16'(mag);
        end
        return v;
    endfunction

    task automatic run_random(input int n_items);
        int neg_pct;
        int run_left;
        run_left = 0;
        neg_pct  = 50;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(3, 40);
                case ($urandom_range(0, 5))
                    0:       neg_pct = 0;
                    1:       neg_pct = 100;
                    2:       neg_pct = 50;
                    3:       neg_pct = 10;
                    4:       neg_pct = 90;
                    default: neg_pct = $urandom_range(0, 100);
                endcase
            end
            send_sample(draw_sample(neg_pct));
            run_left--;
        end
    endtask

    // request source and phase sequencing
    initial begin : sample_side
        int wlen;
        int eff_len;
        int mfill;
        int hlev;
        int llev;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset
        foreach (corner_samples[k]) send_sample(corner_samples[k]);
        run_random(60);

        // single slot window, levels at the far ends
        apply_setting(1, 0, 65536, 0);
        run_random(30);
        // zero length acts as one, both conditions always true
        apply_setting(0, 1, 0, 65536);
        run_random(30);
        // widest window, evaluated only when full
        apply_setting(256, 256, 52429, 32768);
        run_random(300);
        // oversized length, min fill never reached, levels beyond one
        apply_setting(511, 511, 131071, 131071);
        run_random(30);
        // short window with narrow levels
        apply_setting(4, 2, 65535, 1);
        run_random(60);

        // random settings, small windows mostly
        while (samples_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: wlen = $urandom_range(1, 16);
                7, 8:                wlen = $urandom_range(17, 64);
                default:             wlen = $urandom_range(0, 511);
            endcase
            eff_len = (wlen == 0) ? 1 : ((wlen > 256) ? 256 : wlen);
            mfill = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(0, eff_len);
            hlev = ($urandom_range(0, 9) == 0) ? $urandom_range(65537, 131071)
                                               : $urandom_range(0, 65536);
            llev = ($urandom_range(0, 9) == 0) ? $urandom_range(65537, 131071)
                                               : $urandom_range(0, 65536);
            apply_setting(wlen, mfill, hlev, llev);
            run_random((eff_len > 64) ? 300 : 3 * eff_len + 20);
        end

        drain_window();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // result sink with random stalls and one long hold-off
    initial begin : result_side
        int                gap;
        bit                held_off;
        t_coherence_result got;
        held_off = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = receiver_idles ? $urandom_range(0, 15) : 0;
            if (!held_off && results_taken == STALL_AT) begin
                gap      = STALL_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.coherence    = o_coherence;
            got.high_event   = o_high_event;
            got.low_event    = o_low_event;
            got.high_total   = o_high_event_count;
            got.low_total    = o_low_event_count;
            got.sample_total = o_sample_count;
            sb.check_result(got);
            results_taken++;
        end
    end

    // run time limit
    initial begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
